// File: rtl/core/pbmt_pkg.sv
// Shared constants, codes and types of the breakpoint match table.
package pbmt_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned ADDRESS_BITS  = 32;

  // Stored key width: the 32-bit address field masked to ADDRESS_BITS.
  localparam int unsigned KEY_W = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ADD       = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_QUERY     = 3'd3,
    CMD_EXCEPTION = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             enabled;
    logic             hit;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic    pause_request;
    status_e status;
    logic    present;
    logic    present_enabled;
  } result_t;

endpackage

// File: rtl/core/pbmt_entry_ram.sv
// Entry store: one write port, one read port, registered read data.
module pbmt_entry_ram import pbmt_pkg::*; (
  input  logic     clk_i,
  input  ram_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pbmt_ctrl.sv
// Command sequencer: walks the entry store, updates hit marks, commits table changes.
module pbmt_ctrl import pbmt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       in_cmd_i,
  input  logic [KEY_W-1:0] in_key_i,
  input  logic             in_en_i,
  input  logic             boe_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o,
  output ram_req_t         ram_req_o,
  input  entry_t           ram_rdata_i
);

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic               en_q, en_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               chk_q, chk_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   found_idx_q, found_idx_d;
  logic               found_en_q, found_en_d;
  logic               free_q, free_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic               pause_q, pause_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  logic scan_cmd, rd_issue, key_eq, ent_valid, commit;

  assign scan_cmd  = (in_cmd_i == CMD_TICK) || (in_cmd_i == CMD_ADD) ||
                     (in_cmd_i == CMD_REMOVE) || (in_cmd_i == CMD_QUERY);
  assign rd_issue  = (state_q == S_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));
  assign ent_valid = valid_q[chk_idx_q];
  assign key_eq    = (ram_rdata_i.key == key_q);
  assign commit    = (state_q == S_FINISH) && res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = scan_cmd ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (!rd_issue && !chk_q) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    key_d       = key_q;
    en_d        = en_q;
    cnt_d       = cnt_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_en_d  = found_en_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    pause_d     = pause_q;
    valid_d     = valid_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = chk_idx_q;
    ram_req_o.wdata = ram_rdata_i;
    ram_req_o.re    = rd_issue;
    ram_req_o.raddr = cnt_q[IDX_W-1:0];

    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_FINISH);
    res_o       = '{pause_request: 1'b0, status: ST_OK, present: 1'b0,
                    present_enabled: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(in_cmd_i);
          key_d   = in_key_i;
          en_d    = in_en_i;
          cnt_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          pause_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          cnt_d     = cnt_q + CNT_W'(1);
          chk_d     = 1'b1;
          chk_idx_d = cnt_q[IDX_W-1:0];
        end
        if (chk_q) begin
          if (ent_valid && key_eq && !found_q) begin
            found_d     = 1'b1;
            found_idx_d = chk_idx_q;
            found_en_d  = ram_rdata_i.enabled;
          end
          if (!ent_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          // hit-mark update; write-back slot trails the read slot by one
          if (cmd_q == CMD_TICK && ent_valid) begin
            if (key_eq && ram_rdata_i.enabled && !ram_rdata_i.hit) begin
              ram_req_o.we        = 1'b1;
              ram_req_o.wdata.hit = 1'b1;
              pause_d             = 1'b1;
            end else if (ram_rdata_i.hit && !key_eq) begin
              ram_req_o.we        = 1'b1;
              ram_req_o.wdata.hit = 1'b0;
            end
          end
        end
      end
      S_FINISH: begin
        case (cmd_q)
          CMD_TICK: res_o.pause_request = pause_q;
          CMD_ADD: begin
            if (found_q)      res_o.status = ST_DUPLICATE;
            else if (!free_q) res_o.status = ST_FULL;
            else              res_o.status = ST_OK;
          end
          CMD_REMOVE: res_o.status = found_q ? ST_OK : ST_NOT_FOUND;
          CMD_QUERY: begin
            res_o.status          = found_q ? ST_OK : ST_NOT_FOUND;
            res_o.present         = found_q;
            res_o.present_enabled = found_q && found_en_q;
          end
          CMD_EXCEPTION: res_o.pause_request = boe_i;
          default: ;
        endcase
        if (commit) begin
          case (cmd_q)
            CMD_ADD: begin
              if (!found_q && free_q) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = free_idx_q;
                ram_req_o.wdata = '{key: key_q, enabled: en_q, hit: 1'b0};
                valid_d[free_idx_q] = 1'b1;
              end
            end
            CMD_REMOVE: if (found_q) valid_d[found_idx_q] = 1'b0;
            CMD_CLEAR:  valid_d = '0;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      chk_q   <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    en_q        <= en_d;
    chk_idx_q   <= chk_idx_d;
    found_q     <= found_d;
    found_idx_q <= found_idx_d;
    found_en_q  <= found_en_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    pause_q     <= pause_d;
  end

  // write-back never lands on the slot being read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.we && ram_req_o.re) |-> (ram_req_o.waddr != ram_req_o.raddr))
    else $error("entry store read and write hit the same slot");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_ENTRIES))
    else $error("scan counter past table end");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && cmd_q == CMD_CLEAR) |=> (valid_q == '0))
    else $error("clear left valid entries");

  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_FINISH) |-> (cnt_q == CNT_W'(TABLE_ENTRIES)))
    else $error("scan ended before all slots were checked");

endmodule

// File: rtl/core/pc_breakpoint_match_table_top.sv
// Top level of the breakpoint match table: stream ports, APB register, result register.
//
//  channel   dir  handshake                  contents
//  s_axis    in   tvalid/tready              tuser[2:0] command; tdata address, enable_bit
//  m_axis    out  tvalid/tready              tdata pause, status, present, present_enabled
//  apb       in   psel/penable (pready=1)    reg 0 at 0x0: break_on_exception
//
// Tick, add, remove and query walk the entry store one slot per cycle through its
// single read port. Exception, clear and unknown commands skip the walk.
// Reset clears the per-slot valid flops at once; no clearing pass is needed.
// A result waits in the output register while the next word is already taken;
// a held output stalls only the commit of the following word.
module pc_breakpoint_match_table_top import pbmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [31:0] address, [32] enable_bit, [39:33] zero
  input  logic [39:0] s_axis_tdata_i,
  // tuser: [2:0] command
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [0] pause_request, [2:1] status, [3] present, [4] present_enabled, [7:5] zero
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic     boe_q, boe_d;
  logic     out_vld_q, out_vld_d;
  result_t  out_q, out_d;
  logic     res_valid, res_ready;
  result_t  res;
  ram_req_t ram_req;
  entry_t   ram_rdata;
  logic     cfg_wr;

  // register index is paddr[2]; low bits are the byte offset
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && !paddr_i[2];
  assign prdata_o = paddr_i[2] ? 32'd0 : {31'd0, boe_q};
  assign boe_d    = cfg_wr ? pwdata_i[0] : boe_q;

  pbmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_key_i    (s_axis_tdata_i[KEY_W-1:0]),
    .in_en_i     (s_axis_tdata_i[32]),
    .boe_i       (boe_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  pbmt_entry_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // output register: free, or being drained this cycle
  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boe_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      boe_q     <= boe_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'd0, out_q.present_enabled, out_q.present, out_q.status,
                            out_q.pause_request};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second word taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=> (out_vld_q && $stable(out_q)))
    else $error("held result overwritten");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_vld_q)
    else $error("committed result not registered");

endmodule

// File: test/tb.sv
// Self-checking stream testbench for the breakpoint match table top level.
module tb import pbmt_pkg::*;;

  // APB byte address of break_on_exception (register 0)
  localparam logic [2:0] BOE_REG_ADDR = 3'd0;
  // Unused command codes: the block must answer them with an all-zero word
  localparam logic [2:0] CMD_SPARE_6  = 3'd6;
  localparam logic [2:0] CMD_SPARE_7  = 3'd7;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned PHASE_WORDS = 220;
  // Quiet time after the last result before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 25;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic        en;
  } bp_cmd_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic [39:0] s_axis_tdata_i  = '0;   // [31:0] address, [32] enable_bit, [39:33] zero
  logic [2:0]  s_axis_tuser_i  = 3'd0; // [2:0] command
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  m_axis_tdata_o;         // [0] pause, [2:1] status, [3] present, [4] present_enabled
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic        psel_i          = 1'b0;
  logic        penable_i       = 1'b0;
  logic        pwrite_i        = 1'b0;
  logic [2:0]  paddr_i         = '0;
  logic [31:0] pwdata_i        = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  pc_breakpoint_match_table_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .psel_i         (psel_i),
    .penable_i      (penable_i),
    .pwrite_i       (pwrite_i),
    .paddr_i        (paddr_i),
    .pwdata_i       (pwdata_i),
    .prdata_o       (prdata_o),
    .pready_o       (pready_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the breakpoint table and the exception-break register
  logic             bp_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0] bp_addr  [TABLE_ENTRIES];
  logic             bp_en    [TABLE_ENTRIES];
  logic             bp_hit   [TABLE_ENTRIES];
  logic             boe_shadow = 1'b0;

  bp_cmd_t pending_cmds[$];        // words waiting for the driver
  result_t expected_responses[$];  // predicted result words, oldest first

  logic [31:0] addr_pool [POOL_SIZE];
  logic [31:0] last_pc = '0;

  int errors     = 0;
  int words_in   = 0;
  int words_out  = 0;
  int n_pause    = 0;
  int n_dup      = 0;
  int n_full     = 0;
  int n_miss     = 0;
  int n_present  = 0;

  int burst_left = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  int holds_done = 0;
  int ready_mode = 0;
  int mode_left  = 0;
  logic [15:0] ready_pat = 16'hFFFF;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Next result word of the table for one command; updates the shadow state.
  function automatic result_t table_response(input logic [2:0] cmd, input logic [31:0] pc,
                                             input logic en);
    result_t r;
    int      slot;
    int      free_slot;
    r = '{pause_request: 1'b0, status: ST_OK, present: 1'b0, present_enabled: 1'b0};
    slot = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && bp_valid[i] && bp_addr[i] == pc[KEY_W-1:0]) slot = i;
      if (free_slot < 0 && !bp_valid[i]) free_slot = i;
    end
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (bp_valid[i]) begin
            if (bp_addr[i] == pc[KEY_W-1:0] && bp_en[i] && !bp_hit[i]) begin
              bp_hit[i] = 1'b1;
              r.pause_request = 1'b1;
            end else if (bp_hit[i] && bp_addr[i] != pc[KEY_W-1:0]) begin
              bp_hit[i] = 1'b0;  // PC moved away: re-arm
            end
          end
        end
      end
      CMD_ADD: begin
        if (slot >= 0) r.status = ST_DUPLICATE;
        else if (free_slot < 0) r.status = ST_FULL;
        else begin
          bp_valid[free_slot] = 1'b1;
          bp_addr[free_slot]  = pc[KEY_W-1:0];
          bp_en[free_slot]    = en;
          bp_hit[free_slot]   = 1'b0;
        end
      end
      CMD_REMOVE: begin
        if (slot >= 0) bp_valid[slot] = 1'b0;
        else r.status = ST_NOT_FOUND;
      end
      CMD_QUERY: begin
        if (slot >= 0) begin
          r.present = 1'b1;
          r.present_enabled = bp_en[slot];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_EXCEPTION: r.pause_request = boe_shadow;
      CMD_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) bp_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_addr(input int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Mostly well-formed traffic on a small address pool so the table fills,
  // duplicates occur and ticks land on stored breakpoints; the rest is noise.
  function automatic bp_cmd_t random_cmd(input int unsigned add_pct);
    bp_cmd_t c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c.en = $urandom_range(0, 3) != 0;
    if (r < 35) begin
      c.cmd = CMD_TICK;
      // repeat the PC often so hit marks get exercised
      if ($urandom_range(0, 99) < 40) c.addr = last_pc;
      else c.addr = pick_addr(80);
      last_pc = c.addr;
    end else if (r < 35 + add_pct) begin
      c.cmd  = CMD_ADD;
      c.addr = pick_addr(90);
    end else if (r < 92) begin
      c.cmd  = ($urandom_range(0, 99) < 40) ? CMD_REMOVE : CMD_QUERY;
      c.addr = pick_addr(85);
    end else if (r < 97) begin
      c.cmd  = CMD_EXCEPTION;
      c.addr = $urandom;
    end else if (r < 98) begin
      c.cmd  = CMD_CLEAR;
      c.addr = $urandom;
    end else begin
      c.cmd  = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
      c.addr = $urandom;
    end
    return c;
  endfunction

  task automatic push_cmd(input logic [2:0] cmd, input logic [31:0] addr, input logic en);
    pending_cmds.insert(pending_cmds.size(), '{cmd: cmd, addr: addr, en: en});
  endtask

  // Block counts as idle once nothing is queued, offered or outstanding.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || s_axis_tvalid_i || expected_responses.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of break_on_exception, then a read back of the same register.
  task automatic set_break_on_exception(input logic val);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= BOE_REG_ADDR;
    pwdata_i  <= {31'b0, val};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    boe_shadow = val;
    // read setup follows the write access directly
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    if (prdata_o !== {31'b0, val})
      report_mismatch($sformatf("break_on_exception read back %h, wrote %0b", prdata_o, val));
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers words from pending_cmds in bursts with random gaps. The
  // prediction is taken at the accepting edge, from the values then on the bus.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bp_cmd_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_responses.insert(expected_responses.size(),
                                  table_response(s_axis_tuser_i, s_axis_tdata_i[31:0],
                                                 s_axis_tdata_i[32]));
        words_in <= words_in + 1;
      end
      // a new word may only be put up once the current one is gone
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left        <= gap_left - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          s_axis_tuser_i  <= nxt.cmd;
          s_axis_tdata_i  <= {7'b0, nxt.en, nxt.addr};
          s_axis_tvalid_i <= 1'b1;
          if (burst_left <= 1) begin
            // end of burst: choose the gap and the next burst length
            case ($urandom_range(0, 19))
              0:        gap_left <= $urandom_range(20, 40);
              1, 2, 3:  gap_left <= $urandom_range(5, 12);
              4, 5, 6,
              7, 8, 9:  gap_left <= $urandom_range(1, 4);
              default:  gap_left <= 0;
            endcase
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Long output hold-offs, counted here: the sender keeps offering meanwhile,
  // so the result register fills and the input must back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && words_in >= 120) ||
                 (holds_done == 1 && words_in >= 560)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver ready: changes mode at random intervals (always ready, coin
  // flip, rotating pattern, mostly stalled).
  always @(posedge clk_i or negedge rst_ni) begin
    logic rdy;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      ready_mode      <= 0;
      mode_left       <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(16, 200);
        ready_pat  <= $urandom;
      end else begin
        mode_left <= mode_left - 1;
        ready_pat <= {ready_pat[14:0], ready_pat[15]};
      end
      case (ready_mode)
        0:       rdy = 1'b1;
        1:       rdy = $urandom_range(0, 1);
        2:       rdy = ready_pat[0];
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      m_axis_tready_i <= rdy && (hold_left == 0);
    end
  end

  // Monitor: every accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_t want;
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", m_axis_tdata_o));
      end else begin
        want = expected_responses.pop_front();
        words_out++;
        if (m_axis_tdata_o[0] !== want.pause_request)
          report_mismatch($sformatf("word %0d pause_request %b, want %b", words_out,
                                    m_axis_tdata_o[0], want.pause_request));
        if (m_axis_tdata_o[2:1] !== want.status)
          report_mismatch($sformatf("word %0d status %0d, want %0d", words_out,
                                    m_axis_tdata_o[2:1], want.status));
        if (m_axis_tdata_o[3] !== want.present)
          report_mismatch($sformatf("word %0d present %b, want %b", words_out,
                                    m_axis_tdata_o[3], want.present));
        if (m_axis_tdata_o[4] !== want.present_enabled)
          report_mismatch($sformatf("word %0d present_enabled %b, want %b", words_out,
                                    m_axis_tdata_o[4], want.present_enabled));
        if (want.pause_request)         n_pause++;
        if (want.status == ST_DUPLICATE) n_dup++;
        if (want.status == ST_FULL)      n_full++;
        if (want.status == ST_NOT_FOUND) n_miss++;
        if (want.present)               n_present++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and phase control. Register writes happen only with the block
  // drained; break_on_exception alternates between its two values.
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      bp_valid[i] = 1'b0;
      bp_addr[i]  = '0;
      bp_en[i]    = 1'b0;
      bp_hit[i]   = 1'b0;
    end
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    addr_pool[3] = addr_pool[2] ^ 32'h1;          // one-bit neighbors
    addr_pool[5] = addr_pool[4] ^ 32'h8000_0000;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    set_break_on_exception(1'b0);

    // extremes, duplicates, disabled entries, hit mark re-arm, lookups that miss
    push_cmd(CMD_ADD,       32'h0000_0000, 1'b1);
    push_cmd(CMD_ADD,       32'hFFFF_FFFF, 1'b0);
    push_cmd(CMD_ADD,       32'h0000_0000, 1'b0);  // duplicate, enable kept
    push_cmd(CMD_QUERY,     32'h0000_0000, 1'b0);
    push_cmd(CMD_QUERY,     32'hFFFF_FFFF, 1'b1);
    push_cmd(CMD_QUERY,     32'h1234_5678, 1'b0);  // absent, must not insert
    push_cmd(CMD_TICK,      32'h0000_0000, 1'b0);  // pause, hit mark set
    push_cmd(CMD_TICK,      32'h0000_0000, 1'b1);  // already hit, no pause
    push_cmd(CMD_TICK,      32'hFFFF_FFFF, 1'b0);  // disabled match; re-arms slot 0
    push_cmd(CMD_TICK,      32'h0000_0000, 1'b0);  // pause again
    push_cmd(CMD_EXCEPTION, 32'hFFFF_FFFF, 1'b1);  // no pause while register clear
    push_cmd(CMD_REMOVE,    32'h5555_AAAA, 1'b0);
    push_cmd(CMD_REMOVE,    32'h0000_0000, 1'b0);
    push_cmd(CMD_TICK,      32'h0000_0000, 1'b0);
    push_cmd(CMD_ADD,       32'h0000_0000, 1'b1);  // lowest free slot, hit clear
    push_cmd(CMD_TICK,      32'h0000_0000, 1'b0);
    push_cmd(CMD_SPARE_6,   32'hFFFF_FFFF, 1'b1);
    push_cmd(CMD_SPARE_7,   32'h0000_0000, 1'b0);
    push_cmd(CMD_CLEAR,     32'h0000_0000, 1'b0);
    push_cmd(CMD_QUERY,     32'hFFFF_FFFF, 1'b0);
    wait_idle();

    set_break_on_exception(1'b1);
    push_cmd(CMD_EXCEPTION, 32'h0000_0000, 1'b0);
    push_cmd(CMD_ADD,       32'hAAAA_AAAA, 1'b1);
    push_cmd(CMD_TICK,      32'hAAAA_AAAA, 1'b0);
    push_cmd(CMD_TICK,      32'h5555_5555, 1'b0);
    wait_idle();

    // random phases: balanced, add-heavy twice to reach a full table, then balanced again
    for (int ph = 0; ph < 4; ph++) begin
      set_break_on_exception(ph[0]);
      for (int n = 0; n < PHASE_WORDS; n++)
        pending_cmds.insert(pending_cmds.size(),
                            random_cmd((ph == 1 || ph == 2) ? 45 : 25));
      wait_idle();
    end

    $display("Covered %0d words in, %0d results out: %0d pauses, %0d hits on lookup,",
             words_in, words_out, n_pause, n_present);
    $display("  %0d duplicate adds, %0d adds to a full table, %0d misses, %0d long stalls.",
             n_dup, n_full, n_miss, holds_done);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #(6_000_000);
    $display("Timeout: %0d words in, %0d results out", words_in, words_out);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
